>>> rtl/clt_pkg.sv
`timescale 1ns / 1ps

package clt_pkg;

   localparam int KW_COUNT = 5;
   localparam int KW_SLOTS = 5;

   localparam logic [4:0] KIND_IDENT   = 5'd0;
   localparam logic [4:0] KIND_NUMBER  = 5'd6;
   localparam logic [4:0] KIND_PLUS    = 5'd7;
   localparam logic [4:0] KIND_MINUS   = 5'd8;
   localparam logic [4:0] KIND_STAR    = 5'd9;
   localparam logic [4:0] KIND_SLASH   = 5'd10;
   localparam logic [4:0] KIND_COMMENT = 5'd11;
   localparam logic [4:0] KIND_ASSIGN  = 5'd12;
   localparam logic [4:0] KIND_EQEQ    = 5'd13;
   localparam logic [4:0] KIND_NOT     = 5'd14;
   localparam logic [4:0] KIND_NEQ     = 5'd15;
   localparam logic [4:0] KIND_LT      = 5'd16;
   localparam logic [4:0] KIND_LE      = 5'd17;
   localparam logic [4:0] KIND_GT      = 5'd18;
   localparam logic [4:0] KIND_GE      = 5'd19;
   localparam logic [4:0] KIND_SEMI    = 5'd20;
   localparam logic [4:0] KIND_LPAREN  = 5'd21;
   localparam logic [4:0] KIND_RPAREN  = 5'd22;
   localparam logic [4:0] KIND_LBRACE  = 5'd23;
   localparam logic [4:0] KIND_RBRACE  = 5'd24;
   localparam logic [4:0] KIND_END     = 5'd25;
   localparam logic [4:0] KIND_ERROR   = 5'd26;

   localparam logic [4:0] KIND_KW_FIRST = 5'd1;
   localparam logic [4:0] KIND_KW_LAST  = 5'd5;

   typedef logic [KW_SLOTS-1:0][7:0] kw_text_type;

   localparam kw_text_type KW_TEXT [KW_COUNT] = '{
      {8'h00, "n", "i", "a", "m"},
      {8'h00, 8'h00, 8'h00, "f", "i"},
      {8'h00, "e", "s", "l", "e"},
      {8'h00, 8'h00, 8'h00, "o", "d"},
      {"e", "l", "i", "h", "w"}
   };
   localparam logic [7:0] KW_LEN [KW_COUNT] = '{8'd4, 8'd2, 8'd4, 8'd2, 8'd5};

   typedef struct packed {
      logic        last;
      logic [15:0] start_column;
      logic [15:0] start_line;
      logic [7:0]  token_length;
      logic [4:0]  kind;
   } token_type;

endpackage

>>> rtl/c_like_lexer_tokenizer.sv
`timescale 1ns / 1ps

// channel   | dir | payload
// req_      | in  | tdata[7:0] ch
// rsp_      | out | tdata[4:0] kind, [12:5] token_length, [28:13] start_line,
//           |     | [44:29] start_column, tlast last
//
// one byte per cycle while req_tready is high; the lexer step is one pass of
// logic from the state registers into a two-entry result buffer
// a byte that yields two tokens blocks the next byte while the
// second token drains
// req_tready follows reset, the buffer and rsp_tready, never req_tvalid
// synchronous reset clears the lexer state, position counters and buffer

module c_like_lexer_tokenizer
   import clt_pkg::*;
#(
   parameter int MAX_TOKEN_LENGTH = 255
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // ch
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [47:0] rsp_tdata,   // kind, token_length, start_line, start_column, pad
   output logic        rsp_tlast    // last
);

   localparam logic [7:0] LEN_LIMIT = (MAX_TOKEN_LENGTH < 255) ? 8'(MAX_TOKEN_LENGTH) : 8'd255;

   localparam logic [4:0] ST_IDLE     = 5'd0;
   localparam logic [4:0] ST_IDENT    = 5'd1;
   localparam logic [4:0] ST_SIGN     = 5'd2;
   localparam logic [4:0] ST_INT      = 5'd3;
   localparam logic [4:0] ST_DOT      = 5'd4;
   localparam logic [4:0] ST_FRAC     = 5'd5;
   localparam logic [4:0] ST_EXP      = 5'd6;
   localparam logic [4:0] ST_EXPSIGN  = 5'd7;
   localparam logic [4:0] ST_EXPDIG   = 5'd8;
   localparam logic [4:0] ST_EXPDOT   = 5'd9;
   localparam logic [4:0] ST_EXPFRAC  = 5'd10;
   localparam logic [4:0] ST_SLASH    = 5'd11;
   localparam logic [4:0] ST_COMM     = 5'd12;
   localparam logic [4:0] ST_COMMSTAR = 5'd13;
   localparam logic [4:0] ST_EQ       = 5'd14;
   localparam logic [4:0] ST_BANG     = 5'd15;
   localparam logic [4:0] ST_LT       = 5'd16;
   localparam logic [4:0] ST_GT       = 5'd17;

   logic [4:0]  st_ff, st_in;
   logic        sign_ff, sign_in;
   logic [7:0]  len_ff, len_in;
   kw_text_type kw_ff, kw_in;
   logic [15:0] line_ff, line_in;
   logic [15:0] col_ff, col_in;
   logic [15:0] tsl_ff, tsl_in;
   logic [15:0] tsc_ff, tsc_in;
   logic        minus_ff, minus_in;

   token_type   s0_ff, s0_in, s1_ff, s1_in;
   logic        v0_ff, v0_in, v1_ff, v1_in;

   logic        acc, pop;
   logic [7:0]  c;
   logic        dig, letter, ee;
   logic [7:0]  len_grow;
   logic [4:0]  kw_kind;
   logic [4:0]  one_kind;
   logic        redo, emit_a, emit_b;
   logic [4:0]  kind_a, kind_b;
   logic [7:0]  len_a;
   token_type   tok_a, tok_b;

   assign c      = req_tdata;
   assign dig    = (c >= "0") && (c <= "9");
   assign letter = ((c >= "A") && (c <= "Z")) || ((c >= "a") && (c <= "z"));
   assign ee     = (c == "e") || (c == "E");
   assign len_grow = (len_ff < LEN_LIMIT) ? len_ff + 8'd1 : len_ff;

   assign req_tready = !reset && !v1_ff && (!v0_ff || rsp_tready);
   assign acc = req_tvalid && req_tready;
   assign pop = rsp_tvalid && rsp_tready;

   always_comb begin
      kw_kind = KIND_IDENT;
      for (int k = KW_COUNT - 1; k >= 0; k--) begin
         logic hit;
         hit = (len_ff == KW_LEN[k]);
         for (int j = 0; j < KW_SLOTS; j++) begin
            if ((8'(j) < KW_LEN[k]) && (kw_ff[j] != KW_TEXT[k][j])) begin
               hit = 1'b0;
            end
         end
         if (hit) begin
            kw_kind = KIND_KW_FIRST + 5'(k);
         end
      end
   end

   always_comb begin
      case (st_ff)
         ST_EQ:   one_kind = KIND_ASSIGN;
         ST_BANG: one_kind = KIND_NOT;
         ST_LT:   one_kind = KIND_LT;
         default: one_kind = KIND_GT;
      endcase
   end

   always_comb begin
      st_in    = st_ff;
      sign_in  = sign_ff;
      len_in   = len_ff;
      kw_in    = kw_ff;
      tsl_in   = tsl_ff;
      tsc_in   = tsc_ff;
      minus_in = minus_ff;
      redo     = 1'b0;
      emit_a   = 1'b0;
      kind_a   = KIND_ERROR;
      len_a    = len_ff;
      emit_b   = 1'b0;
      kind_b   = KIND_ERROR;

      // position of this byte
      if (c == 8'h0a) begin
         line_in = (line_ff != 16'hffff) ? line_ff + 16'd1 : line_ff;
         col_in  = 16'd0;
      end else begin
         line_in = line_ff;
         col_in  = (col_ff != 16'hffff) ? col_ff + 16'd1 : col_ff;
      end

      case (st_ff)
         ST_IDENT: begin
            if (letter || dig) begin
               if (len_ff < 8'(KW_SLOTS)) begin
                  kw_in[len_ff[2:0]] = c;
               end
               len_in = len_grow;
            end else begin
               emit_a = 1'b1; kind_a = kw_kind; sign_in = 1'b0; redo = 1'b1;
            end
         end
         ST_SIGN: begin
            if (dig && sign_ff) begin
               st_in = ST_INT; len_in = len_grow;
            end else begin
               emit_a = 1'b1; kind_a = minus_ff ? KIND_MINUS : KIND_PLUS; len_a = 8'd1;
               sign_in = 1'b1; redo = 1'b1;
            end
         end
         ST_INT, ST_FRAC: begin
            if (dig) begin
               len_in = len_grow;
            end else if (ee) begin
               st_in = ST_EXP; len_in = len_grow;
            end else if ((c == ".") && (st_ff == ST_INT)) begin
               st_in = ST_DOT; len_in = len_grow;
            end else begin
               emit_a = 1'b1; kind_a = KIND_NUMBER; sign_in = 1'b0; redo = 1'b1;
            end
         end
         ST_DOT, ST_EXPSIGN, ST_EXPDOT: begin
            if (dig) begin
               st_in = (st_ff == ST_DOT) ? ST_FRAC :
                       (st_ff == ST_EXPSIGN) ? ST_EXPDIG : ST_EXPFRAC;
               len_in = len_grow;
            end else begin
               emit_a = 1'b1; kind_a = KIND_ERROR; sign_in = 1'b0; redo = 1'b1;
            end
         end
         ST_EXP: begin
            if ((c == "+") || (c == "-")) begin
               st_in = ST_EXPSIGN; len_in = len_grow;
            end else if (dig) begin
               st_in = ST_EXPDIG; len_in = len_grow;
            end else begin
               emit_a = 1'b1; kind_a = KIND_ERROR; len_a = len_ff - 8'd1;
               sign_in = 1'b0; redo = 1'b1;
            end
         end
         ST_EXPDIG, ST_EXPFRAC: begin
            if (dig) begin
               len_in = len_grow;
            end else if ((c == ".") && (st_ff == ST_EXPDIG)) begin
               st_in = ST_EXPDOT; len_in = len_grow;
            end else begin
               emit_a = 1'b1; kind_a = KIND_NUMBER; sign_in = 1'b0; redo = 1'b1;
            end
         end
         ST_SLASH: begin
            if (c == "*") begin
               st_in = ST_COMM; len_in = len_grow;
            end else begin
               emit_a = 1'b1; kind_a = KIND_SLASH; len_a = 8'd1; sign_in = 1'b1; redo = 1'b1;
            end
         end
         ST_COMM, ST_COMMSTAR: begin
            if (c == "#") begin
               emit_a = 1'b1; kind_a = KIND_ERROR; redo = 1'b1;
            end else if ((c == "/") && (st_ff == ST_COMMSTAR)) begin
               len_in = len_grow;
               emit_a = 1'b1; kind_a = KIND_COMMENT; len_a = len_grow; st_in = ST_IDLE;
            end else begin
               len_in = len_grow;
               st_in = (c == "*") ? ST_COMMSTAR : ST_COMM;
            end
         end
         ST_EQ, ST_BANG, ST_LT, ST_GT: begin
            if (c == "=") begin
               emit_a = 1'b1; kind_a = one_kind + 5'd1; len_a = 8'd2; st_in = ST_IDLE;
            end else begin
               emit_a = 1'b1; kind_a = one_kind; len_a = 8'd1;
               if (one_kind == KIND_ASSIGN) begin
                  sign_in = 1'b1;
               end
               redo = 1'b1;
            end
         end
         default: begin
            redo = 1'b1;
         end
      endcase

      // byte taken again from the idle state
      if (redo) begin
         st_in = ST_IDLE;
         if (!((c == " ") || (c == 8'h0a) || (c == 8'h09))) begin
            len_in   = 8'd1;
            tsl_in   = line_in;
            tsc_in   = col_in;
            kw_in[0] = c;
            if (letter) begin
               st_in = ST_IDENT;
            end else if (dig) begin
               sign_in = 1'b1; st_in = ST_INT;
            end else begin
               case (c)
                  "+", "-": begin
                     minus_in = (c == "-"); st_in = ST_SIGN;
                  end
                  "/": st_in = ST_SLASH;
                  "=": st_in = ST_EQ;
                  "!": st_in = ST_BANG;
                  "<": st_in = ST_LT;
                  ">": st_in = ST_GT;
                  "*": begin
                     sign_in = 1'b1; emit_b = 1'b1; kind_b = KIND_STAR;
                  end
                  ";": begin
                     emit_b = 1'b1; kind_b = KIND_SEMI;
                  end
                  "(": begin
                     sign_in = 1'b1; emit_b = 1'b1; kind_b = KIND_LPAREN;
                  end
                  ")": begin
                     sign_in = 1'b0; emit_b = 1'b1; kind_b = KIND_RPAREN;
                  end
                  "{": begin
                     sign_in = 1'b0; emit_b = 1'b1; kind_b = KIND_LBRACE;
                  end
                  "}": begin
                     sign_in = 1'b0; emit_b = 1'b1; kind_b = KIND_RBRACE;
                  end
                  "#": begin
                     emit_b = 1'b1; kind_b = KIND_END;
                  end
                  default: begin
                     emit_b = 1'b1; kind_b = KIND_ERROR;
                  end
               endcase
            end
         end
      end
   end

   always_comb begin
      tok_a.kind         = kind_a;
      tok_a.token_length = len_a;
      tok_a.start_line   = tsl_ff;
      tok_a.start_column = tsc_ff;
      tok_a.last         = !emit_b;
      tok_b.kind         = kind_b;
      tok_b.token_length = 8'd1;
      tok_b.start_line   = line_in;
      tok_b.start_column = col_in;
      tok_b.last         = 1'b1;
   end

   // result buffer
   always_comb begin
      s0_in = s0_ff;
      s1_in = s1_ff;
      v0_in = v0_ff;
      v1_in = v1_ff;
      if (acc) begin
         v0_in = emit_a || emit_b;
         v1_in = emit_a && emit_b;
         s0_in = emit_a ? tok_a : tok_b;
         s1_in = tok_b;
      end else if (pop) begin
         s0_in = s1_ff;
         v0_in = v1_ff;
         v1_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff    <= ST_IDLE;
         sign_ff  <= 1'b1;
         len_ff   <= 8'd0;
         line_ff  <= 16'd1;
         col_ff   <= 16'd0;
         tsl_ff   <= 16'd1;
         tsc_ff   <= 16'd0;
         minus_ff <= 1'b0;
         v0_ff    <= 1'b0;
         v1_ff    <= 1'b0;
      end else begin
         if (acc) begin
            st_ff    <= st_in;
            sign_ff  <= sign_in;
            len_ff   <= len_in;
            line_ff  <= line_in;
            col_ff   <= col_in;
            tsl_ff   <= tsl_in;
            tsc_ff   <= tsc_in;
            minus_ff <= minus_in;
         end
         v0_ff <= v0_in;
         v1_ff <= v1_in;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         kw_ff <= kw_in;
      end
      s0_ff <= s0_in;
      s1_ff <= s1_in;
   end

   assign rsp_tvalid = v0_ff;
   assign rsp_tdata  = {3'b000, s0_ff.start_column, s0_ff.start_line,
                        s0_ff.token_length, s0_ff.kind};
   assign rsp_tlast  = s0_ff.last;

endmodule

>>> rtl/clt_checker.sv
`timescale 1ns / 1ps

module clt_checker
   import clt_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [47:0] rsp_tdata,
   input logic        rsp_tlast
);

   logic        kw_hit;
   logic [7:0]  rsp_len;
   logic [4:0]  rsp_kind;

   assign rsp_kind = rsp_tdata[4:0];
   assign rsp_len  = rsp_tdata[12:5];
   assign kw_hit   = (rsp_kind >= KIND_KW_FIRST) && (rsp_kind <= KIND_KW_LAST);

   // a pending result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
      else $error("result changed while stalled");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_kind <= KIND_ERROR && rsp_len != 8'd0 && rsp_tdata[28:13] != 16'd0)
      else $error("bad kind, length or line");

   a_kw_len: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && kw_hit |-> rsp_len >= 8'd2 && rsp_len <= 8'd5)
      else $error("keyword with bad length");

   // two results from one byte: the first is not last and blocks the next request
   a_pair: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tlast |-> !req_tready)
      else $error("request taken while a token pair drains");

   a_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("result valid after reset");

endmodule

bind c_like_lexer_tokenizer clt_checker u_clt_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tlast  (rsp_tlast)
);
